FILE: rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int IDX_W       = 10;
	localparam int DIR_ENTRIES = 1 << IDX_W;
	localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int FREE_W      = $clog2(TABLE_SLOTS + 1);
	localparam int POOL_DEPTH  = (1 << SLOT_W) * DIR_ENTRIES;
	localparam int DIR_W       = 1 + 12 + SLOT_W;

	localparam logic [1:0] CMD_MAP       = 2'd0;
	localparam logic [1:0] CMD_UNMAP     = 2'd1;
	localparam logic [1:0] CMD_TRANSLATE = 2'd2;

	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
	localparam logic [1:0] ST_NO_TABLE   = 2'd2;

	localparam logic [11:0] BIT_PRESENT  = 12'h001;
	localparam logic [11:0] BIT_WRITABLE = 12'h002;

	typedef struct packed {
		logic              present;
		logic [11:0]       flags;
		logic [SLOT_W-1:0] slot;
	} dir_entry_t;

	typedef enum logic [1:0] {
		OP_REPORT,
		OP_WRITE,
		OP_CLEAR_WRITE,
		OP_READ
	} op_t;

	// One job for the pool side: data is the entry to write, or the page offset
	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [IDX_W-1:0]  idx;
		logic [31:0]       data;
		logic [1:0]        status;
	} qitem_t;

endpackage

FILE: rtl/tlpt_ram.sv
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/tlpt_front.sv
// ----------------------------------------------------------------------------
// tlpt_front
// Accepts commands, looks up the directory, allocates tables and queues pool jobs.
// ----------------------------------------------------------------------------
module tlpt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      command,
	input  logic [31:0]     virt_addr,
	input  logic [31:0]     phys_addr,
	input  logic [11:0]     page_flags,
	output logic            push,
	output tlpt_pkg::qitem_t push_item,
	input  logic            q_full
);
	import tlpt_pkg::*;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOKUP} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    clr_cnt_q;
	logic [FREE_W-1:0]   free_q;
	logic [1:0]          cmd_q;
	logic [31:0]         va_q;
	logic [31:0]         pa_q;
	logic [11:0]         fl_q;

	logic                accept;
	logic                alloc;
	logic                dir_we;
	logic [IDX_W-1:0]    dir_waddr;
	logic [DIR_W-1:0]    dir_wdata;
	logic [DIR_W-1:0]    dir_rdata;
	dir_entry_t          de;
	dir_entry_t          new_de;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign de       = dir_entry_t'(dir_rdata);
	assign push     = (state_q == S_LOOKUP) && !q_full;

	always_comb begin
		alloc                = 1'b0;
		push_item.op         = OP_REPORT;
		push_item.slot       = de.slot;
		push_item.idx        = va_q[21:12];
		push_item.data       = '0;
		push_item.status     = ST_DONE;
		new_de.present       = 1'b1;
		new_de.flags         = fl_q | BIT_PRESENT | BIT_WRITABLE;
		new_de.slot          = free_q[SLOT_W-1:0];
		unique case (cmd_q)
			CMD_MAP: begin
				push_item.data = {pa_q[31:12], fl_q | BIT_PRESENT};
				if (de.present) begin
					push_item.op = OP_WRITE;
				end else if (free_q >= FREE_W'(TABLE_SLOTS)) begin
					push_item.status = ST_NO_TABLE;
				end else begin
					alloc          = 1'b1;
					push_item.op   = OP_CLEAR_WRITE;
					push_item.slot = free_q[SLOT_W-1:0];
				end
			end
			CMD_UNMAP: begin
				if (de.present) begin
					push_item.op = OP_WRITE;
				end else begin
					push_item.status = ST_NOT_MAPPED;
				end
			end
			CMD_TRANSLATE: begin
				push_item.data = {20'd0, va_q[11:0]};
				if (de.present) begin
					push_item.op = OP_READ;
				end else begin
					push_item.status = ST_NOT_MAPPED;
				end
			end
			default: begin
				push_item.status = ST_DONE;
			end
		endcase
	end

	assign dir_we    = (state_q == S_CLEAR) || (push && alloc);
	assign dir_waddr = (state_q == S_CLEAR) ? clr_cnt_q : va_q[31:22];
	assign dir_wdata = (state_q == S_CLEAR) ? '0 : DIR_W'(new_de);

	tlpt_ram #(
		.WIDTH (DIR_W),
		.DEPTH (DIR_ENTRIES)
	) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.re    (accept),
		.raddr (virt_addr[31:22]),
		.rdata (dir_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			free_q    <= '0;
			cmd_q     <= '0;
			va_q      <= '0;
			pa_q      <= '0;
			fl_q      <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == IDX_W'(DIR_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= command;
						va_q    <= virt_addr;
						pa_q    <= phys_addr;
						fl_q    <= page_flags;
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					// hold the directory read data until the queue has room
					if (push) begin
						state_q <= S_IDLE;
						if (alloc) begin
							free_q <= free_q + 1'b1;
						end
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full)) else $error("push into full queue");
	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FREE_W'(TABLE_SLOTS)) else $error("table count overrun");
	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_LOOKUP) else $error("accepted beat not looked up");
`endif
endmodule

FILE: rtl/tlpt_queue.sv
// ----------------------------------------------------------------------------
// tlpt_queue
// Two-entry queue of pool jobs between the front and back parts.
// ----------------------------------------------------------------------------
module tlpt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tlpt_pkg::qitem_t push_item,
	input  logic             pop,
	output tlpt_pkg::qitem_t head,
	output logic             full,
	output logic             empty
);
	import tlpt_pkg::*;

	qitem_t     mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

FILE: rtl/tlpt_back.sv
// ----------------------------------------------------------------------------
// tlpt_back
// Carries out pool jobs: table clear, entry write, entry read, and the result beat.
// ----------------------------------------------------------------------------
module tlpt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tlpt_pkg::qitem_t head,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      phys_result,
	output logic [1:0]       status
);
	import tlpt_pkg::*;

	localparam int AW = SLOT_W + IDX_W;

	typedef enum logic [1:0] {S_RUN, S_CLEAR, S_WRITE, S_READ} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             out_valid_q;
	logic [31:0]      result_q;
	logic [1:0]       status_q;

	logic             out_free;
	logic             load;
	logic [31:0]      ld_result;
	logic [1:0]       ld_status;
	logic             pool_we;
	logic [AW-1:0]    pool_waddr;
	logic [31:0]      pool_wdata;
	logic             pool_re;
	logic [31:0]      pool_rdata;

	assign out_free    = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign phys_result = result_q;
	assign status      = status_q;

	always_comb begin
		pop        = 1'b0;
		load       = 1'b0;
		ld_result  = '0;
		ld_status  = head.status;
		pool_we    = 1'b0;
		pool_waddr = {head.slot, head.idx};
		pool_wdata = head.data;
		pool_re    = 1'b0;
		unique case (state_q)
			S_RUN: begin
				if (!empty) begin
					unique case (head.op)
						OP_REPORT: begin
							pop  = out_free;
							load = out_free;
						end
						OP_WRITE: begin
							pool_we = out_free;
							pop     = out_free;
							load    = out_free;
						end
						OP_READ:        pool_re = 1'b1;
						OP_CLEAR_WRITE: pool_we = 1'b0;
						default:        pool_we = 1'b0;
					endcase
				end
			end
			S_CLEAR: begin
				pool_we    = 1'b1;
				pool_waddr = {head.slot, clr_cnt_q};
				pool_wdata = '0;
			end
			S_WRITE: begin
				pool_we = out_free;
				pop     = out_free;
				load    = out_free;
			end
			S_READ: begin
				pop  = out_free;
				load = out_free;
				if (pool_rdata[0]) begin
					ld_result = {pool_rdata[31:12], head.data[11:0]};
					ld_status = ST_DONE;
				end else begin
					ld_status = ST_NOT_MAPPED;
				end
			end
			default: pool_we = 1'b0;
		endcase
	end

	tlpt_ram #(
		.WIDTH (32),
		.DEPTH (POOL_DEPTH)
	) u_pool_ram (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.re    (pool_re),
		.raddr ({head.slot, head.idx}),
		.rdata (pool_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
			status_q    <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				result_q    <= ld_result;
				status_q    <= ld_status;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_RUN: begin
					if (!empty && head.op == OP_CLEAR_WRITE) begin
						clr_cnt_q <= '0;
						state_q   <= S_CLEAR;
					end else if (!empty && head.op == OP_READ) begin
						state_q <= S_READ;
					end
				end
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == IDX_W'(DIR_ENTRIES - 1)) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (pop) begin
						state_q <= S_RUN;
					end
				end
				S_READ: begin
					// read data holds until the result beat is loaded
					if (pop) begin
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end
endmodule

FILE: rtl/two_level_page_table_engine_top.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine_top
// Two-level page table: directory lookup front end, page table pool back end.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-entry directory, one entry a cycle,
// and takes no command until the sweep ends. The front end reads the
// directory, then classifies and queues, waiting while the queue is full;
// the back end writes or reports in one step, translates by a pool read
// and a result load. A map that allocates a page table also clears its
// 1024 entries in the back end, one pool entry a cycle. A two-entry queue
// lets the front end take commands while a table clears or a result waits.
module two_level_page_table_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] virt_addr,
	input  logic [31:0] phys_addr,
	input  logic [11:0] page_flags,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] phys_result,
	output logic [1:0]  status
);
	import tlpt_pkg::*;

	qitem_t push_item;
	qitem_t head;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_empty;

	tlpt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.virt_addr  (virt_addr),
		.phys_addr  (phys_addr),
		.page_flags (page_flags),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	tlpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	tlpt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.phys_result (phys_result),
		.status      (status)
	);
endmodule
